// ===== rtl/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// grr_pkg
// Shared widths, reset values, the 5x5 glyph ROM and the row mask expansion
// for the glyph row rasterizer.
// ----------------------------------------------------------------------------
package grr_pkg;

  // Field widths
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned PITCH_W     = 13;
  localparam int unsigned ROW_ADDR_W  = 25;
  localparam int unsigned MASK_W      = 10;
  localparam int unsigned GLYPH_W     = 25;
  localparam int unsigned GLYPH_SIDE  = 5;
  localparam int unsigned PROD_W      = COORD_W + PITCH_W;

  // Stream word widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 72;

  // Row sequencing
  localparam int unsigned ROW_CNT_W   = 4;
  localparam logic [ROW_CNT_W-1:0] LAST_ROW = ROW_CNT_W'(9);

  // Register reset and parameter defaults
  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(640);
  localparam int unsigned DEFAULT_ADDR_WIDTH   = 25;
  localparam int unsigned DEFAULT_CHAR_ADVANCE = 12;

  // One result word as it leaves the row sequencer
  typedef struct packed {
    logic                  last_row;
    logic [COLOR_W-1:0]    pixel_color;
    logic [MASK_W-1:0]     pixel_mask;
    logic [ROW_ADDR_W-1:0] row_address;
  } out_row_t;

  // Glyph ROM: bit 24 is the top-left cell, rows of five cells.
  // Upper case folds onto lower case; anything without a glyph is blank.
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0]  c;
    logic [GLYPH_W-1:0] g;
    c = code;
    if (code >= "A" && code <= "Z") begin
      c = code + CODE_W'(8'h20);
    end
    case (c)
      "a":   g = 25'h0E8FE31;
      "b":   g = 25'h1E8FA3E;
      "c":   g = 25'h0F8420F;
      "d":   g = 25'h1E8C63E;
      "e":   g = 25'h1F87A1F;
      "f":   g = 25'h1F87210;
      "g":   g = 25'h0F85E2E;
      "h":   g = 25'h118FE31;
      "i":   g = 25'h0421084;
      "j":   g = 25'h021085C;
      "k":   g = 25'h12A6292;
      "l":   g = 25'h108421F;
      "m":   g = 25'h1AAD631;
      "n":   g = 25'h11CD671;
      "o":   g = 25'h0E8C62E;
      "p":   g = 25'h1E8FA10;
      "q":   g = 25'h0E8C66F;
      "r":   g = 25'h1E8FA92;
      "s":   g = 25'h0F8383E;
      "t":   g = 25'h1F21084;
      "u":   g = 25'h118C62F;
      "v":   g = 25'h118A944;
      "w":   g = 25'h118D6AA;
      "x":   g = 25'h1151151;
      "y":   g = 25'h118BC2E;
      "z":   g = 25'h1F1111F;
      "0":   g = 25'h0E9D72E;
      "1":   g = 25'h046108E;
      "2":   g = 25'h0E8991F;
      "3":   g = 25'h1E0983E;
      "4":   g = 25'h1097C42;
      "5":   g = 25'h1F8783E;
      "6":   g = 25'h0F87A2E;
      "7":   g = 25'h1F08884;
      "8":   g = 25'h0E8BA2E;
      "9":   g = 25'h0E8BC2E;
      "!":   g = 25'h0421004;
      "?":   g = 25'h0E08804;
      ":":   g = 25'h0001004;
      "=":   g = 25'h000380E;
      ",":   g = 25'h0000044;
      ".":   g = 25'h0000004;
      "-":   g = 25'h0003800;
      "(":   g = 25'h0221082;
      ")":   g = 25'h0410844;
      "#":   g = 25'h1FFFFFF;
      8'h27: g = 25'h0420000;  // apostrophe
      "*":   g = 25'h1577DD5;
      "/":   g = 25'h0111110;
      8'h22: g = 25'h0E8FE31;  // double quote
      default: g = '0;
    endcase
    return g;
  endfunction

  // Pick glyph row gy and double each cell horizontally; bit 0 is leftmost.
  function automatic logic [MASK_W-1:0] row_mask(input logic [GLYPH_W-1:0] glyph,
                                                 input logic [2:0]         gy);
    logic [GLYPH_SIDE-1:0] cells;
    logic [MASK_W-1:0]     m;
    case (gy)
      3'd0:    cells = glyph[24:20];
      3'd1:    cells = glyph[19:15];
      3'd2:    cells = glyph[14:10];
      3'd3:    cells = glyph[9:5];
      3'd4:    cells = glyph[4:0];
      default: cells = '0;
    endcase
    for (int c = 0; c < GLYPH_SIDE; c++) begin
      m[2*c]   = cells[GLYPH_SIDE-1-c];
      m[2*c+1] = cells[GLYPH_SIDE-1-c];
    end
    return m;
  endfunction

endpackage

// ===== rtl/glyph_row_rasterizer.sv =====
// ----------------------------------------------------------------------------
// glyph_row_rasterizer
// Character generator: 5x5 glyph ROM scaled 2x into ten 10-pixel row words,
// each with its frame-buffer word address, pixel mask, color and last flag.
//
//   Port group        Dir  Handshake                     Carries
//   s_axis_*          in   s_axis_tvalid/s_axis_tready   one character
//   m_axis_*          out  m_axis_tvalid/m_axis_tready   one glyph row
//   cfg_*             in   cfg_valid_i/cfg_ready_o       pitch register
//
// Each character yields ten row words, one per cycle from the row sequencer
// unless m_axis stalls; the next character is taken while the last row of
// the previous one is emitted. The first row word passes through the three
// front stages, the sequencer and the output register.
// Reset empties the pipeline and sets pitch to 640; no warm-up sweep.
// A stall on m_axis holds the output word and backs up the front stages.
// ----------------------------------------------------------------------------
module glyph_row_rasterizer #(
  parameter int unsigned ADDR_WIDTH   = grr_pkg::DEFAULT_ADDR_WIDTH,
  parameter int unsigned CHAR_ADVANCE = grr_pkg::DEFAULT_CHAR_ADVANCE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input character stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] char_code, [17:8] char_position, [29:18] origin_x,
  // [41:30] origin_y, [73:42] color, [79:74] zero
  input  logic [grr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Row word stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [24:0] row_address, [34:25] pixel_mask, [66:35] pixel_color, [71:67] zero
  output logic [grr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  // Pitch register write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [grr_pkg::PITCH_W-1:0]     cfg_data_i
);
  import grr_pkg::*;

  logic [PITCH_W-1:0]    pitch_q;

  logic                  fr_valid;
  logic                  fr_ready;
  logic [GLYPH_W-1:0]    fr_glyph;
  logic [ADDR_WIDTH-1:0] fr_start;
  logic [COLOR_W-1:0]    fr_color;

  out_row_t              out_row;

  // Pitch register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= PITCH_RESET;
    end else if (cfg_valid_i) begin
      pitch_q <= cfg_data_i;
    end
  end

  grr_front #(
    .ADDR_WIDTH   (ADDR_WIDTH),
    .CHAR_ADVANCE (CHAR_ADVANCE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s_axis_tvalid),
    .ready_o         (s_axis_tready),
    .char_code_i     (s_axis_tdata[7:0]),
    .char_position_i (s_axis_tdata[17:8]),
    .origin_x_i      (s_axis_tdata[29:18]),
    .origin_y_i      (s_axis_tdata[41:30]),
    .color_i         (s_axis_tdata[73:42]),
    .pitch_i         (pitch_q),
    .valid_o         (fr_valid),
    .ready_i         (fr_ready),
    .glyph_o         (fr_glyph),
    .start_addr_o    (fr_start),
    .color_o         (fr_color)
  );

  grr_expand #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_expand (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (fr_valid),
    .in_ready_o   (fr_ready),
    .glyph_i      (fr_glyph),
    .start_addr_i (fr_start),
    .color_i      (fr_color),
    .pitch_i      (pitch_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_row_o    (out_row)
  );

  // Pack the row word
  assign m_axis_tdata = {5'b0, out_row.pixel_color, out_row.pixel_mask,
                         out_row.row_address};
  assign m_axis_tlast = out_row.last_row;

endmodule

// ===== rtl/grr_front.sv =====
// ----------------------------------------------------------------------------
// grr_front
// Three-stage front pipeline: capture the character, look up its glyph and
// form the row product and column offset, then sum them into the address of
// the glyph's first row.
// ----------------------------------------------------------------------------
module grr_front #(
  parameter int unsigned ADDR_WIDTH   = grr_pkg::DEFAULT_ADDR_WIDTH,
  parameter int unsigned CHAR_ADVANCE = grr_pkg::DEFAULT_CHAR_ADVANCE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [grr_pkg::CODE_W-1:0]    char_code_i,
  input  logic [grr_pkg::POS_W-1:0]     char_position_i,
  input  logic [grr_pkg::COORD_W-1:0]   origin_x_i,
  input  logic [grr_pkg::COORD_W-1:0]   origin_y_i,
  input  logic [grr_pkg::COLOR_W-1:0]   color_i,
  input  logic [grr_pkg::PITCH_W-1:0]   pitch_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [grr_pkg::GLYPH_W-1:0]   glyph_o,
  output logic [ADDR_WIDTH-1:0]         start_addr_o,
  output logic [grr_pkg::COLOR_W-1:0]   color_o
);
  import grr_pkg::*;

  // Stage 1: raw input capture
  logic                 v1_q;
  logic [CODE_W-1:0]    code1_q;
  logic [POS_W-1:0]     pos1_q;
  logic [COORD_W-1:0]   ox1_q;
  logic [COORD_W-1:0]   oy1_q;
  logic [COLOR_W-1:0]   color1_q;

  // Stage 2: glyph, row product, column offset
  logic                 v2_q;
  logic [GLYPH_W-1:0]   glyph2_q;
  logic [PROD_W-1:0]    prod2_q;
  logic [ADDR_WIDTH-1:0] base2_q;
  logic [COLOR_W-1:0]   color2_q;

  // Stage 3: first row address
  logic                 v3_q;
  logic [GLYPH_W-1:0]   glyph3_q;
  logic [ADDR_WIDTH-1:0] start3_q;
  logic [COLOR_W-1:0]   color3_q;

  logic adv1, adv2, adv3;

  // Each stage moves when the one after it has room
  assign adv3    = !v3_q || ready_i;
  assign adv2    = !v2_q || adv3;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      code1_q  <= char_code_i;
      pos1_q   <= char_position_i;
      ox1_q    <= origin_x_i;
      oy1_q    <= origin_y_i;
      color1_q <= color_i;
    end
    if (adv2 && v1_q) begin
      glyph2_q <= glyph_of(code1_q);
      prod2_q  <= PROD_W'(oy1_q) * PROD_W'(pitch_i);
      base2_q  <= ADDR_WIDTH'(ox1_q)
                + ADDR_WIDTH'(pos1_q) * ADDR_WIDTH'(CHAR_ADVANCE);
      color2_q <= color1_q;
    end
    if (adv3 && v2_q) begin
      glyph3_q <= glyph2_q;
      start3_q <= ADDR_WIDTH'(prod2_q) + base2_q;
      color3_q <= color2_q;
    end
  end

  assign valid_o      = v3_q;
  assign glyph_o      = glyph3_q;
  assign start_addr_o = start3_q;
  assign color_o      = color3_q;

endmodule

// ===== rtl/grr_expand.sv =====
// ----------------------------------------------------------------------------
// grr_expand
// Row sequencer and output register: steps one character through its ten
// pixel rows, one row per cycle unless the output stalls, adding the pitch to the address each row.
// ----------------------------------------------------------------------------
module grr_expand #(
  parameter int unsigned ADDR_WIDTH = grr_pkg::DEFAULT_ADDR_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [grr_pkg::GLYPH_W-1:0] glyph_i,
  input  logic [ADDR_WIDTH-1:0]       start_addr_i,
  input  logic [grr_pkg::COLOR_W-1:0] color_i,
  input  logic [grr_pkg::PITCH_W-1:0] pitch_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output grr_pkg::out_row_t           out_row_o
);
  import grr_pkg::*;

  logic                  busy_q;
  logic [ROW_CNT_W-1:0]  row_q;
  logic [GLYPH_W-1:0]    glyph_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [COLOR_W-1:0]    color_q;

  logic                  out_valid_q;
  out_row_t              out_q;
  out_row_t              out_d;

  logic emit, last, load;

  // Emit a row whenever the output register is free or being drained
  assign emit       = busy_q && (!out_valid_q || out_ready_i);
  assign last       = (row_q == LAST_ROW);
  assign in_ready_o = !busy_q || (emit && last);
  assign load       = in_valid_i && in_ready_o;

  // Build the current row
  always_comb begin
    out_d.row_address = ROW_ADDR_W'(addr_q);
    out_d.pixel_mask  = row_mask(glyph_q, row_q[ROW_CNT_W-1:1]);
    out_d.pixel_color = color_q;
    out_d.last_row    = last;
  end

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        row_q  <= '0;
      end else if (emit) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        row_q <= row_q + ROW_CNT_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      glyph_q <= glyph_i;
      addr_q  <= start_addr_i;
      color_q <= color_i;
    end else if (emit) begin
      addr_q <= addr_q + ADDR_WIDTH'(pitch_i);
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_q;

  // Row counter stays within the ten rows while a character is active
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> row_q <= LAST_ROW)
    else $error("row counter beyond last row");

  // A non-final row advances to the next row of the same character
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !last) |=> busy_q && row_q == ROW_CNT_W'($past(row_q) + ROW_CNT_W'(1)))
    else $error("row sequence skipped or stalled");

  // After the final row the sequencer is idle or restarted at the top row
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (!busy_q || row_q == '0))
    else $error("character not restarted at top row");

  // A stalled output word is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit)
    else $error("row emitted over a stalled word");

endmodule
